/* hdl/npcs_pkg.sv */
// Shared types and constants for the nearest palette colour search block.
// Holds the controller/datapath command and status structs and the field widths.
// No dependencies.
package npcs_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned COMP_W = 6;
  localparam int unsigned DIST_W = 14;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_PALETTE_ENTRIES = 256;
  localparam int unsigned DEF_COMPONENT_BITS  = 6;

  // Request kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;  // store one palette entry
    logic load;   // latch the pixel and restart the search
    logic issue;  // read the next palette entry
    logic flush;  // drop entries still in the pipeline
  } npcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_last;  // the read address is the last palette entry
    logic pipe_busy;  // an entry is still on its way to the compare stage
    logic exact_hit;  // the compare stage sees a distance of zero
  } npcs_status_t;

endpackage

/* hdl/nearest_palette_color_search.sv */
// A palette write request is stored when it is taken and does not make the block busy.
// A lookup request scans the palette in index order through the single read port, one
// entry per cycle, and stops early when an entry matches exactly; then the result strobe
// is raised. Busy falls as the strobe ends, and no new request is taken before that.
// The receiver cannot stall the result.
// Reset clears the controller and pipeline flags; palette contents are undefined until written.
module nearest_palette_color_search
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
  parameter int unsigned COMPONENT_BITS  = DEF_COMPONENT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [IDX_W-1:0]   entry_index_i,
  input  logic [COMP_W-1:0]  red_i,
  input  logic [COMP_W-1:0]  green_i,
  input  logic [COMP_W-1:0]  blue_i,
  input  logic               end_of_image_i,
  output logic               result_valid_o,
  output logic [IDX_W-1:0]   palette_index_o,
  output logic [DIST_W-1:0]  distance_o,
  output logic               last_pixel_o
);

  npcs_cmd_t    cmd;
  npcs_status_t status;

  // Sequencing of requests and the scan.
  npcs_controller u_controller (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (kind_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Palette memory and distance evaluation.
  npcs_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .COMPONENT_BITS  (COMPONENT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .end_of_image_i  (end_of_image_i),
    .palette_index_o (palette_index_o),
    .distance_o      (distance_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

/* hdl/npcs_datapath.sv */
// Datapath of the nearest palette colour search: palette memory, distance
// pipeline and best-match registers. Depends on npcs_pkg.
module npcs_datapath
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
  parameter int unsigned COMPONENT_BITS  = DEF_COMPONENT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  npcs_cmd_t          cmd_i,
  output npcs_status_t       status_o,
  input  logic [IDX_W-1:0]   entry_index_i,
  input  logic [COMP_W-1:0]  red_i,
  input  logic [COMP_W-1:0]  green_i,
  input  logic [COMP_W-1:0]  blue_i,
  input  logic               end_of_image_i,
  output logic [IDX_W-1:0]   palette_index_o,
  output logic [DIST_W-1:0]  distance_o,
  output logic               last_pixel_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned EW = 3 * CB;
  localparam int unsigned SW = 2 * CB;
  localparam int unsigned DW = 2 * CB + 2;
  localparam logic [DW-1:0] START_BOUND = DW'(3) << (2 * CB);
  localparam logic [AW-1:0] LAST_ADDR   = AW'(PALETTE_ENTRIES - 1);

  // Palette memory: {red, green, blue} per entry, contents undefined until written.
  logic [EW-1:0] palette_mem [PALETTE_ENTRIES];

  logic [AW-1:0] addr_q;
  logic [AW-1:0] rd_idx_q, sq_idx_q;
  logic [EW-1:0] rd_data_q;
  logic          rd_valid_q, sq_valid_q;
  logic [CB-1:0] pix_r_q, pix_g_q, pix_b_q;
  logic          last_q;
  logic [SW-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic [SW-1:0] sq_r_d, sq_g_d, sq_b_d;
  logic [DW-1:0] best_dist_q;
  logic [AW-1:0] best_idx_q;
  logic [DW-1:0] dist_sum;
  logic          in_range;
  logic          better;

  // Writes beyond the palette size are ignored.
  assign in_range = {1'b0, entry_index_i} < (IDX_W + 1)'(PALETTE_ENTRIES);

  // Palette write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && in_range) begin
      palette_mem[entry_index_i[AW-1:0]] <= {CB'(red_i), CB'(green_i), CB'(blue_i)};
    end
    rd_data_q <= palette_mem[addr_q];
  end

  // Read address counter walks the palette in index order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.load) begin
      addr_q <= '0;
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // Valid flags travelling with each palette entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      sq_valid_q <= 1'b0;
    end else if (cmd_i.flush) begin
      rd_valid_q <= 1'b0;
      sq_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.issue;
      sq_valid_q <= rd_valid_q;
    end
  end

  // Squared component differences of the entry just read.
  function automatic logic [SW-1:0] sq_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SW'(d) * SW'(d);
  endfunction

  always_comb begin
    sq_r_d = sq_diff(rd_data_q[EW-1:2*CB], pix_r_q);
    sq_g_d = sq_diff(rd_data_q[2*CB-1:CB], pix_g_q);
    sq_b_d = sq_diff(rd_data_q[CB-1:0],    pix_b_q);
  end

  // Pixel latch and square stage registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_r_q <= CB'(red_i);
      pix_g_q <= CB'(green_i);
      pix_b_q <= CB'(blue_i);
      last_q  <= end_of_image_i;
    end
    if (cmd_i.issue) begin
      rd_idx_q <= addr_q;
    end
    sq_r_q   <= sq_r_d;
    sq_g_q   <= sq_g_d;
    sq_b_q   <= sq_b_d;
    sq_idx_q <= rd_idx_q;
  end

  // Sum and compare: the first strictly smaller distance wins.
  assign dist_sum = DW'(sq_r_q) + DW'(sq_g_q) + DW'(sq_b_q);
  assign better   = sq_valid_q && (dist_sum < best_dist_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_dist_q <= START_BOUND;
      best_idx_q  <= '0;
    end else if (better) begin
      best_dist_q <= dist_sum;
      best_idx_q  <= sq_idx_q;
    end
  end

  // Status back to the controller.
  always_comb begin
    status_o.addr_last = (addr_q == LAST_ADDR);
    status_o.pipe_busy = rd_valid_q || sq_valid_q;
    status_o.exact_hit = sq_valid_q && (dist_sum == '0);
  end

  // Result fields stay on the best-match registers.
  assign palette_index_o = IDX_W'(best_idx_q);
  assign distance_o      = DIST_W'(best_dist_q);
  assign last_pixel_o    = last_q;

endmodule

/* hdl/npcs_controller.sv */
// Controller of the nearest palette colour search: sequences the palette
// scan and raises the result strobe. Depends on npcs_pkg.
module npcs_controller
  import npcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         kind_i,
  input  npcs_status_t status_i,
  output npcs_cmd_t    cmd_o,
  output logic         busy,
  output logic         result_valid_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_RESULT);
  assign take           = start && !busy;

  // Commands to the datapath.
  always_comb begin
    cmd_o.write = take && (kind_i == KIND_WRITE);
    cmd_o.load  = take && (kind_i == KIND_LOOKUP);
    cmd_o.issue = (state_q == ST_SCAN) && !status_i.exact_hit;
    cmd_o.flush = status_i.exact_hit;
  end

  // Next state: scan the entries, let the pipeline empty, show the result; an exact hit goes straight to the result.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && (kind_i == KIND_LOOKUP)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.exact_hit) begin
          state_d = ST_RESULT;
        end else if (status_i.addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.exact_hit || !status_i.pipe_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/npcs_checker.sv */
// Port-level checks for the nearest palette colour search, attached to the top
// level by the bind statement below. Depends on npcs_pkg.
module npcs_checker
  import npcs_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic kind_i,
  input logic result_valid_o
);

  // A result is only shown while a lookup request is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe without a request in progress");

  // A taken lookup request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_LOOKUP)) |=> (busy && !result_valid_o))
    else $error("lookup request did not start a scan");

  // A palette write completes at once and gives no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_WRITE)) |=> (!busy && !result_valid_o))
    else $error("palette write request left the block busy");

  // The result strobe lasts one cycle and the block is then free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy))
    else $error("result strobe not followed by idle");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .result_valid_o (result_valid_o)
);
